[rtl/rlt_pkg.sv]
// shared constants and types for the rms level trigger
package rlt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int ENERGY_W = 36;
  localparam int WTHR_W   = 45;
  localparam int PLEN_W   = 16;
  localparam int PERIOD_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 45;

  localparam int SAMPLES_PER_BLOCK_DEF   = 48;
  localparam int BLOCKS_PER_WINDOW_N_DEF = 400;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd3;

  localparam logic [ENERGY_W-1:0] BLOCK_THR_RST  = 36'd515396076;
  localparam logic [WTHR_W-1:0]   WINDOW_THR_RST = 45'd51539607552;
  localparam logic [PLEN_W-1:0]   PULSE_LEN_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd10;

  typedef struct packed {
    logic led_on;
    logic block_done;
    logic block_loud;
    logic window_checked;
  } rlt_res_t;

endpackage

[rtl/rms_level_trigger_with_pulse_top.sv]
// rms level trigger top level: block energy, led pulse and window ring
// a transaction is registered in stage 1, then stage 2, then the output register
// throughput: one transaction per cycle unless out_ready stalls the output; the ring
// takes at most one read and one write each cycle, reading one stage ahead of its write
// back with one-entry forwarding; reset clears all control state; the ring needs no
// clearing pass since the fill count marks entries not yet written as zero
module rms_level_trigger_with_pulse_top #(
  parameter int SAMPLES_PER_BLOCK   = rlt_pkg::SAMPLES_PER_BLOCK_DEF,
  parameter int BLOCKS_PER_WINDOW_N = rlt_pkg::BLOCKS_PER_WINDOW_N_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic signed [rlt_pkg::SAMPLE_W-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_led_on,
  output logic                           out_block_done,
  output logic                           out_block_loud,
  output logic                           out_window_checked,
  output logic                           out_window_loud,
  input  logic                           cfg_we,
  input  logic [rlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int N      = BLOCKS_PER_WINDOW_N;
  localparam int CNT_W  = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam int PTR_W  = (N > 1) ? $clog2(N) : 1;
  localparam int BS_W   = $clog2(N + 1);
  localparam int WS_W   = rlt_pkg::ENERGY_W + $clog2(N + 1);
  localparam int CMP_W  = (WS_W > rlt_pkg::WTHR_W) ? WS_W : rlt_pkg::WTHR_W;
  localparam int EN_W   = rlt_pkg::ENERGY_W;

  // configuration registers
  logic [EN_W-1:0]              block_thr_r;
  logic [rlt_pkg::WTHR_W-1:0]   window_thr_r;
  logic [rlt_pkg::PLEN_W-1:0]   pulse_len_r;
  logic [rlt_pkg::PERIOD_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_thr_r  <= rlt_pkg::BLOCK_THR_RST;
      window_thr_r <= rlt_pkg::WINDOW_THR_RST;
      pulse_len_r  <= rlt_pkg::PULSE_LEN_RST;
      period_r     <= rlt_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlt_pkg::REG_BLOCK_THR:  block_thr_r  <= cfg_data[EN_W-1:0];
        rlt_pkg::REG_WINDOW_THR: window_thr_r <= cfg_data[rlt_pkg::WTHR_W-1:0];
        rlt_pkg::REG_PULSE_LEN:  pulse_len_r  <= cfg_data[rlt_pkg::PLEN_W-1:0];
        rlt_pkg::REG_PERIOD:     period_r     <= cfg_data[rlt_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_free, s1_free;
  logic in_go, s1_go, s2_go;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign in_go    = in_valid && in_ready;
  assign s1_go    = s1_valid_r && s2_free;
  assign s2_go    = s2_valid_r && out_free;

  // stage 1: square of the sample magnitude
  logic                     s1_func_r;
  logic [rlt_pkg::SQ_W-1:0] s1_sq_r;
  logic [rlt_pkg::SAMPLE_W-1:0] mag;
  logic [2*rlt_pkg::SAMPLE_W-1:0] sq_full;

  assign mag     = in_sample[rlt_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign sq_full = mag * mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_func_r <= in_func;
      s1_sq_r   <= sq_full[rlt_pkg::SQ_W-1:0];
    end
  end

  // stage 2: block accumulation and ring read
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EN_W-1:0]  acc_r, acc_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [EN_W:0]    acc_sum;
  logic [EN_W-1:0]  acc_sat;
  logic             blk_done;

  logic             s2_func_r, s2_done_r;
  logic [EN_W-1:0]  s2_energy_r;
  logic [PTR_W-1:0] s2_ptr_r;

  assign acc_sum  = {1'b0, acc_r} + (EN_W + 1)'(s1_sq_r);
  assign acc_sat  = acc_sum[EN_W] ? {EN_W{1'b1}} : acc_sum[EN_W-1:0];
  assign blk_done = !s1_func_r && (cnt_r == CNT_W'(SAMPLES_PER_BLOCK - 1));

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    ptr_nxt = ptr_r;
    if (s1_go && !s1_func_r) begin
      if (blk_done) begin
        cnt_nxt = '0;
        acc_nxt = '0;
        ptr_nxt = (ptr_r == PTR_W'(N - 1)) ? '0 : ptr_r + 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        acc_nxt = acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      acc_r      <= '0;
      ptr_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      ptr_r <= ptr_nxt;
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_func_r   <= s1_func_r;
      s2_done_r   <= blk_done;
      s2_energy_r <= acc_sat;
      s2_ptr_r    <= ptr_r;
    end
  end

  // energy ring
  logic [EN_W-1:0] ring_mem [N];
  logic [EN_W-1:0] rd_data_r;
  logic [EN_W-1:0] fwd_data_r;
  logic            fwd_sel_r;
  logic            ring_wr;

  assign ring_wr = s2_go && s2_done_r;

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[s2_ptr_r] <= s2_energy_r;
    end
    if (s1_go) begin
      rd_data_r <= ring_mem[ptr_r];
    end
  end

  // write and read of the same entry at one edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (s1_go) begin
      fwd_sel_r <= ring_wr && (s2_ptr_r == ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_data_r <= s2_energy_r;
    end
  end

  // stage 3: window sum, checks and pulse
  logic [WS_W-1:0]  wsum_r, wsum_nxt;
  logic [BS_W-1:0]  seen_r, seen_nxt;
  logic [rlt_pkg::PERIOD_W-1:0] chk_r, chk_nxt, chk_inc;
  logic             pulse_r, pulse_nxt;
  logic [rlt_pkg::PLEN_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [EN_W-1:0]  old_energy;
  logic             full;
  logic             loud;
  logic             checked;
  rlt_pkg::rlt_res_t res;

  logic              out_valid_q;
  rlt_pkg::rlt_res_t out_res_r;
  logic [WS_W-1:0]   out_wsum_r;

  assign full        = (seen_r == BS_W'(N));
  assign old_energy  = !full ? '0 : (fwd_sel_r ? fwd_data_r : rd_data_r);
  assign loud        = s2_done_r && (s2_energy_r > block_thr_r);
  assign elapsed_inc = (elapsed_r != {rlt_pkg::PLEN_W{1'b1}}) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    wsum_nxt    = wsum_r;
    seen_nxt    = seen_r;
    chk_nxt     = chk_r;
    chk_inc     = (chk_r != {rlt_pkg::PERIOD_W{1'b1}}) ? chk_r + 1'b1 : chk_r;
    pulse_nxt   = pulse_r;
    elapsed_nxt = elapsed_r;
    checked     = 1'b0;
    if (s2_go) begin
      if (s2_func_r) begin
        if (pulse_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= pulse_len_r) begin
            pulse_nxt = 1'b0;
          end
        end
      end else if (s2_done_r) begin
        wsum_nxt = wsum_r - WS_W'(old_energy) + WS_W'(s2_energy_r);
        seen_nxt = full ? seen_r : seen_r + 1'b1;
        if (loud && !pulse_r) begin
          pulse_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
        if (seen_nxt == BS_W'(N)) begin
          if (chk_inc >= period_r) begin
            chk_nxt = '0;
            checked = 1'b1;
          end else begin
            chk_nxt = chk_inc;
          end
        end
      end
    end
    res.led_on         = pulse_nxt;
    res.block_done     = s2_done_r;
    res.block_loud     = loud;
    res.window_checked = checked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r      <= '0;
      seen_r      <= '0;
      chk_r       <= '0;
      pulse_r     <= 1'b0;
      elapsed_r   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wsum_r    <= wsum_nxt;
      seen_r    <= seen_nxt;
      chk_r     <= chk_nxt;
      pulse_r   <= pulse_nxt;
      elapsed_r <= elapsed_nxt;
      if (out_free) begin
        out_valid_q <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_res_r  <= res;
      out_wsum_r <= wsum_nxt;
    end
  end

  assign out_valid_r        = out_valid_q;
  assign out_valid          = out_valid_r;
  assign out_led_on         = out_res_r.led_on;
  assign out_block_done     = out_res_r.block_done;
  assign out_block_loud     = out_res_r.block_loud;
  assign out_window_checked = out_res_r.window_checked;
  assign out_window_loud    = out_res_r.window_checked &&
                              (CMP_W'(out_wsum_r) > CMP_W'(window_thr_r));

endmodule

[rtl/rlt_checker.sv]
// port-level checker for the rms level trigger, bound to the top level
module rlt_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_block_done,
  input logic out_block_loud,
  input logic out_window_checked,
  input logic out_window_loud
);

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a loud block is always a completed block
  a_loud_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_loud |-> out_block_done)
    else $error("block loud without block done");

  // window checks only happen at block ends
  a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_checked |-> out_block_done)
    else $error("window check without block done");

  a_wloud_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_loud |-> out_window_checked)
    else $error("window loud without window check");

  // stalled result transaction is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_done))
    else $error("stalled result dropped or changed");

endmodule

bind rms_level_trigger_with_pulse_top rlt_checker u_rlt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_block_done     (out_block_done),
  .out_block_loud     (out_block_loud),
  .out_window_checked (out_window_checked),
  .out_window_loud    (out_window_loud)
);
